>>> hdl/svq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// svq_pkg
// Shared types and constants of the sorted value set quantizer.
// ---------------------------------------------------------------------------
package svq_pkg;
    localparam int STORE_DEPTH = 256;
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam logic signed [32:0] END_MARK = 33'sd2147483647;
    localparam logic [32:0] MAX32 = 33'h0FFFFFFFF;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REDUCE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_ZERO      = 3'd2;
    localparam logic [2:0] ST_REJECT    = 3'd3;
    localparam logic [2:0] ST_REDUCED   = 3'd4;
    localparam logic [2:0] ST_ENTRY     = 3'd5;
    localparam logic [2:0] ST_BADPOS    = 3'd6;
    localparam logic [2:0] ST_CLEARED   = 3'd7;

    localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;
    localparam logic [1:0] REG_SKIP_ZERO   = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_SHIFT_RD,
        S_INS_SHIFT_WR,
        S_INS_DONE,
        S_RED_INIT,
        S_COV_START,
        S_COV_RD,
        S_COV_CHK,
        S_COV_END,
        S_MRG_START,
        S_MRG_RD,
        S_MRG_CHK,
        S_MRG_FILL,
        S_RD_MEM,
        S_RD_OUT,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_GAP0,
        PH_DOUBLE,
        PH_HALF,
        PH_STEP
    } phase_t;
endpackage
`default_nettype wire

>>> hdl/sorted_value_set_quantizer_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_value_set_quantizer_unit
// Sorted distinct-value store with interval-cover reduction.
// ---------------------------------------------------------------------------
// Commands enter on start/func/value/position when busy is low; one result
// comes back per command, shown for one cycle with done high. The receiver
// cannot stall. Configuration goes through the APB port (max_entries at 0x0,
// skip_zero at 0x4); the user must write it only while the unit is idle,
// as the unit does not enforce this. Insert: a linear search over the
// store, reading then comparing each entry, then a shift of the tail one
// entry at a time (read, then write). Reduce: when the count exceeds
// max_entries, repeated greedy cover passes through the value memory's
// single read port: one pass at zero length, up to 32 doubling passes, one
// after the halving and one per step to the next gap (data dependent); then
// a merge pass writing rounded values and group indices. Read goes through
// S_RD_MEM and S_RD_OUT; clear, zero skip and early reject go straight to
// S_DONE. Reset empties the set, no clearing pass.
// ---------------------------------------------------------------------------
module sorted_value_set_quantizer_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         func,
    input  wire logic signed [31:0] value,
    input  wire logic [7:0]         position,
    output logic                    done,
    output logic [2:0]              status,
    output logic [8:0]              distinct_count,
    output logic [8:0]              table_count,
    output logic [31:0]             interval_length,
    output logic signed [31:0]      original_value,
    output logic signed [31:0]      rounded_value,
    output logic [8:0]              table_index,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    localparam int IW = svq_pkg::IDX_W;
    localparam int CW = svq_pkg::CNT_W;

    logic [15:0] max_entries;
    logic        skip_zero;

    svq_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .max_entries(max_entries), .skip_zero(skip_zero)
    );
    assign pready = 1'b1;

    // memories
    logic signed [31:0] val_mem [svq_pkg::STORE_DEPTH];
    logic signed [31:0] rnd_mem [svq_pkg::STORE_DEPTH];
    logic [8:0]         grp_mem [svq_pkg::STORE_DEPTH];

    logic [IW-1:0]      raddr;
    logic signed [31:0] rdata_reg, rrnd_reg;
    logic [8:0]         rgrp_reg;
    logic               vwe, mwe;
    logic [IW-1:0]      vwaddr, mwaddr;
    logic signed [31:0] vwdata, mwrnd;
    logic [8:0]         mwgrp;

    always_ff @(posedge clk)
    begin
        if (vwe)
            val_mem[vwaddr] <= vwdata;
        if (mwe)
        begin
            rnd_mem[mwaddr] <= mwrnd;
            grp_mem[mwaddr] <= mwgrp;
        end
        rdata_reg <= val_mem[raddr];
        rrnd_reg  <= rnd_mem[raddr];
        rgrp_reg  <= grp_mem[raddr];
    end

    svq_pkg::state_t state_reg, state_next;
    svq_pkg::phase_t ph_reg, ph_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] gcnt_reg, gcnt_next;
    logic [31:0]   chosen_reg, chosen_next;
    logic          red_reg, red_next;
    logic [1:0]    func_reg, func_next;
    logic signed [31:0] val_reg, val_next;
    logic [7:0]    pos_reg, pos_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [2:0]    st_reg, st_next;
    logic signed [31:0] ov_reg, ov_next, rv_reg, rv_next;
    logic [8:0]    ti_reg, ti_next;
    // reduce working state
    logic [32:0]   d_reg, d_next, hi_reg, hi_next, ng_reg, ng_next;
    logic signed [32:0] low_reg, low_next, last_reg, last_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] first_reg, first_next;
    logic signed [CW:0] exc_reg, exc_next;
    logic          gap0_reg, gap0_next;

    logic [16:0] m_eff;
    logic signed [32:0] rd33, gapv, mid;
    logic signed [33:0] top;
    logic        k_over;

    assign m_eff  = (max_entries == 16'd0) ? 17'd1 : {1'b0, max_entries};
    assign rd33   = {rdata_reg[31], rdata_reg};
    // low + d can pass 2^32, so one extra bit
    assign top    = {low_reg[32], low_reg} + $signed({1'b0, d_reg});
    assign k_over = {{(17-CW){1'b0}}, k_reg} > m_eff;
    assign mid    = low_reg + ((last_reg - low_reg) >>> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= svq_pkg::S_IDLE;
            cnt_reg    <= '0;
            gcnt_reg   <= '0;
            chosen_reg <= '0;
            red_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            gcnt_reg   <= gcnt_next;
            chosen_reg <= chosen_next;
            red_reg    <= red_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg <= ph_next;   func_reg <= func_next; val_reg <= val_next;
        pos_reg <= pos_next; i_reg <= i_next;       j_reg <= j_next;
        st_reg <= st_next;   ov_reg <= ov_next;     rv_reg <= rv_next;
        ti_reg <= ti_next;   d_reg <= d_next;       hi_reg <= hi_next;
        ng_reg <= ng_next;   low_reg <= low_next;   last_reg <= last_next;
        k_reg <= k_next;     first_reg <= first_next; exc_reg <= exc_next;
        gap0_reg <= gap0_next;
    end

    always_comb
    begin
        state_next = state_reg; ph_next = ph_reg; cnt_next = cnt_reg;
        gcnt_next = gcnt_reg; chosen_next = chosen_reg; red_next = red_reg;
        func_next = func_reg; val_next = val_reg; pos_next = pos_reg;
        i_next = i_reg; j_next = j_reg; st_next = st_reg; ov_next = ov_reg;
        rv_next = rv_reg; ti_next = ti_reg; d_next = d_reg; hi_next = hi_reg;
        ng_next = ng_reg; low_next = low_reg; last_next = last_reg;
        k_next = k_reg; first_next = first_reg; exc_next = exc_reg;
        gap0_next = gap0_reg;
        raddr = i_reg[IW-1:0];
        vwe = 1'b0; vwaddr = j_reg[IW-1:0]; vwdata = val_reg;
        mwe = 1'b0; mwaddr = j_reg[IW-1:0]; mwrnd = mid[31:0];
        mwgrp = {{(9-CW){1'b0}}, k_reg};
        gapv = '0;
        busy = (state_reg != svq_pkg::S_IDLE);
        done = 1'b0;

        case (state_reg)
            svq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    func_next = func; val_next = value; pos_next = position;
                    ov_next = '0; rv_next = '0; ti_next = '0; i_next = '0;
                    case (func)
                        svq_pkg::FUNC_INSERT:
                        begin
                            if (value == 32'sd0 && skip_zero)
                            begin
                                st_next = svq_pkg::ST_ZERO; state_next = svq_pkg::S_DONE;
                            end
                            else if (value == 32'sh7FFFFFFF || red_reg)
                            begin
                                st_next = svq_pkg::ST_REJECT; state_next = svq_pkg::S_DONE;
                            end
                            else
                                state_next = svq_pkg::S_INS_RD;
                        end
                        svq_pkg::FUNC_REDUCE: state_next = svq_pkg::S_RED_INIT;
                        svq_pkg::FUNC_READ:
                        begin
                            if ({1'b0, position} < cnt_reg)
                            begin
                                i_next = {1'b0, position};
                                state_next = svq_pkg::S_RD_MEM;
                            end
                            else
                            begin
                                st_next = svq_pkg::ST_BADPOS; state_next = svq_pkg::S_DONE;
                            end
                        end
                        default:
                        begin
                            cnt_next = '0; gcnt_next = '0; chosen_next = '0;
                            red_next = 1'b0; st_next = svq_pkg::ST_CLEARED;
                            state_next = svq_pkg::S_DONE;
                        end
                    endcase
                end
            end
            // ---------------- insert ----------------
            svq_pkg::S_INS_RD:
            begin
                if (i_reg < cnt_reg)
                    state_next = svq_pkg::S_INS_CMP;
                else if (cnt_reg[CW-1])
                begin
                    st_next = svq_pkg::ST_REJECT; state_next = svq_pkg::S_DONE;
                end
                else
                begin
                    j_next = cnt_reg; state_next = svq_pkg::S_INS_SHIFT_RD;
                end
            end
            svq_pkg::S_INS_CMP:
            begin
                if (rdata_reg < val_reg)
                begin
                    i_next = i_reg + 1'b1; state_next = svq_pkg::S_INS_RD;
                end
                else if (rdata_reg == val_reg)
                begin
                    st_next = svq_pkg::ST_DUP; state_next = svq_pkg::S_DONE;
                end
                else if (cnt_reg[CW-1])
                begin
                    st_next = svq_pkg::ST_REJECT; state_next = svq_pkg::S_DONE;
                end
                else
                begin
                    j_next = cnt_reg; state_next = svq_pkg::S_INS_SHIFT_RD;
                end
            end
            svq_pkg::S_INS_SHIFT_RD:
            begin
                // move entry j-1 up to j until j reaches the insert point
                raddr = j_reg[IW-1:0] - 1'b1;
                if (j_reg == i_reg)
                    state_next = svq_pkg::S_INS_DONE;
                else
                    state_next = svq_pkg::S_INS_SHIFT_WR;
            end
            svq_pkg::S_INS_SHIFT_WR:
            begin
                vwe = 1'b1; vwdata = rdata_reg;
                j_next = j_reg - 1'b1;
                state_next = svq_pkg::S_INS_SHIFT_RD;
            end
            svq_pkg::S_INS_DONE:
            begin
                vwe = 1'b1; vwdata = val_reg;
                cnt_next = cnt_reg + 1'b1;
                st_next = svq_pkg::ST_INSERTED; state_next = svq_pkg::S_DONE;
            end
            // ---------------- reduce ----------------
            svq_pkg::S_RED_INIT:
            begin
                d_next = '0;
                exc_next = $signed({1'b0, cnt_reg}) - $signed(m_eff[CW:0]);
                if ({{(17-CW){1'b0}}, cnt_reg} > m_eff)
                begin
                    ph_next = svq_pkg::PH_GAP0; state_next = svq_pkg::S_COV_START;
                end
                else
                    state_next = svq_pkg::S_MRG_START;
            end
            svq_pkg::S_COV_START:
            begin
                i_next = '0; k_next = '0; ng_next = svq_pkg::END_MARK;
                gap0_next = 1'b1;
                state_next = svq_pkg::S_COV_RD;
            end
            svq_pkg::S_COV_RD:
            begin
                if (i_reg < cnt_reg)
                    state_next = svq_pkg::S_COV_CHK;
                else
                begin
                    // end mark closes the last interval
                    if (!gap0_reg)
                    begin
                        gapv = svq_pkg::END_MARK - low_reg;
                        if ($unsigned(gapv) < ng_reg)
                            ng_next = $unsigned(gapv);
                    end
                    state_next = svq_pkg::S_COV_END;
                end
            end
            svq_pkg::S_COV_CHK:
            begin
                if (gap0_reg)
                begin
                    low_next = rd33; k_next = k_reg + 1'b1; gap0_next = 1'b0;
                    i_next = i_reg + 1'b1; state_next = svq_pkg::S_COV_RD;
                end
                else if (rd33 <= top)
                begin
                    i_next = i_reg + 1'b1; state_next = svq_pkg::S_COV_RD;
                end
                else
                begin
                    gapv = rd33 - low_reg;
                    if ($unsigned(gapv) < ng_reg)
                        ng_next = $unsigned(gapv);
                    low_next = rd33; k_next = k_reg + 1'b1;
                    i_next = i_reg + 1'b1; state_next = svq_pkg::S_COV_RD;
                end
            end
            svq_pkg::S_COV_END:
            begin
                state_next = svq_pkg::S_COV_START;
                case (ph_reg)
                    svq_pkg::PH_GAP0:
                    begin
                        d_next = (ng_reg << 1) > svq_pkg::MAX32 ? svq_pkg::MAX32
                                                                 : ng_reg << 1;
                        ph_next = svq_pkg::PH_DOUBLE;
                    end
                    svq_pkg::PH_DOUBLE:
                    begin
                        if (k_over)
                            d_next = (d_reg << 1) > svq_pkg::MAX32 ? svq_pkg::MAX32
                                                                    : d_reg << 1;
                        else
                        begin
                            hi_next = d_reg; d_next = d_reg >> 1;
                            ph_next = svq_pkg::PH_STEP;
                        end
                    end
                    default:
                    begin
                        if (!k_over)
                            state_next = svq_pkg::S_MRG_START;
                        else if (ng_reg <= d_reg)
                        begin
                            d_next = hi_reg; state_next = svq_pkg::S_MRG_START;
                        end
                        else
                            d_next = ng_reg;
                    end
                endcase
            end
            // merge: i scans, first..last is the current group
            svq_pkg::S_MRG_START:
            begin
                chosen_next = d_reg[31:0];
                i_next = '0; k_next = '0; gap0_next = 1'b1;
                state_next = svq_pkg::S_MRG_RD;
            end
            svq_pkg::S_MRG_RD:
            begin
                if (i_reg < cnt_reg)
                    state_next = svq_pkg::S_MRG_CHK;
                else if (gap0_reg)
                begin
                    gcnt_next = k_reg; red_next = 1'b1;
                    st_next = svq_pkg::ST_REDUCED; state_next = svq_pkg::S_DONE;
                end
                else
                begin
                    j_next = first_reg; state_next = svq_pkg::S_MRG_FILL;
                end
            end
            svq_pkg::S_MRG_CHK:
            begin
                if (!gap0_reg && rd33 <= top)
                begin
                    last_next = rd33; i_next = i_reg + 1'b1;
                    exc_next = exc_reg - 1'b1;
                    if (exc_reg == 1) d_next = '0;
                    state_next = svq_pkg::S_MRG_RD;
                end
                else if (gap0_reg)
                begin
                    low_next = rd33; last_next = rd33; first_next = i_reg;
                    k_next = k_reg + 1'b1; gap0_next = 1'b0;
                    i_next = i_reg + 1'b1; state_next = svq_pkg::S_MRG_RD;
                end
                else
                begin
                    // close group, fill it, then restart at i
                    j_next = first_reg; state_next = svq_pkg::S_MRG_FILL;
                end
            end
            svq_pkg::S_MRG_FILL:
            begin
                mwe = 1'b1;
                if (j_next == i_reg - 1'b1 || j_reg == i_reg - 1'b1)
                begin
                    gap0_next = 1'b1; state_next = svq_pkg::S_MRG_RD;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            // ---------------- read ----------------
            svq_pkg::S_RD_MEM: state_next = svq_pkg::S_RD_OUT;
            svq_pkg::S_RD_OUT:
            begin
                ov_next = rdata_reg;
                rv_next = red_reg ? rrnd_reg : rdata_reg;
                ti_next = red_reg ? rgrp_reg : 9'd0;
                st_next = svq_pkg::ST_ENTRY; state_next = svq_pkg::S_DONE;
            end
            svq_pkg::S_DONE:
            begin
                done = 1'b1; state_next = svq_pkg::S_IDLE;
            end
            default: state_next = svq_pkg::S_IDLE;
        endcase
    end

    assign status          = st_reg;
    assign distinct_count  = {{(9-CW){1'b0}}, cnt_reg};
    assign table_count     = {{(9-CW){1'b0}}, gcnt_reg};
    assign interval_length = chosen_reg;
    assign original_value  = ov_reg;
    assign rounded_value   = rv_reg;
    assign table_index     = ti_reg;
endmodule
`default_nettype wire

>>> hdl/svq_cfg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// svq_cfg
// APB register file: max_entries and skip_zero.
// ---------------------------------------------------------------------------
module svq_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic [15:0]      max_entries,
    output logic             skip_zero
);
    logic [15:0] max_reg;
    logic        skip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= 16'd255;
            skip_reg <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == 3'd0)
                max_reg <= pwdata[15:0];
            else if (paddr == 3'd4)
                skip_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        case (paddr)
            3'd0: prdata = {16'd0, max_reg};
            3'd4: prdata = {31'd0, skip_reg};
            default: prdata = 32'd0;
        endcase
    end

    assign max_entries = max_reg;
    assign skip_zero   = skip_reg;
endmodule
`default_nettype wire

>>> verif/sorted_value_set_quantizer_unit_tb.sv
// ---------------------------------------------------------------------------
// sorted_value_set_quantizer_unit_tb
// Drives insert, reduce, read and clear commands into the quantizer with
// random gaps, predicts every result with a behavioral copy of the sorted
// store and its interval-cover reduction, and checks each result field by
// field. Configuration is changed over APB between phases while idle.
// ---------------------------------------------------------------------------
module sorted_value_set_quantizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint END_VAL = 64'sd2147483647;
    localparam longint SAT32   = 64'sd4294967295;
    localparam int     ITEM_GOAL = 650;

    typedef struct {
        logic [2:0]         st;
        logic [8:0]         dcount;
        logic [8:0]         tcount;
        logic [31:0]        ilen;
        logic signed [31:0] orig;
        logic signed [31:0] rnd;
        logic [8:0]         tidx;
    } quant_result_t;

    typedef struct {
        logic [1:0]         fn;
        logic signed [31:0] val;
        logic [7:0]         pos;
        bit                 typed;
        logic [2:0]         st;
    } cmd_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         func = svq_pkg::FUNC_READ;
    logic signed [31:0] value = '0;
    logic [7:0]         position = '0;
    logic               done;
    logic [2:0]         status;
    logic [8:0]         distinct_count;
    logic [8:0]         table_count;
    logic [31:0]        interval_length;
    logic signed [31:0] original_value;
    logic signed [31:0] rounded_value;
    logic [8:0]         table_index;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    sorted_value_set_quantizer_unit u_dut (.*);

    always #5 clk = ~clk;

    // predictor state
    longint     set_vals [svq_pkg::STORE_DEPTH];
    longint     set_rnd  [svq_pkg::STORE_DEPTH];
    int         set_grp  [svq_pkg::STORE_DEPTH];
    int         set_cnt;
    int         grp_cnt;
    longint     cur_interval;
    bit         is_reduced;
    int         cfg_max_entries;
    bit         cfg_skip_zero;

    quant_result_t pending_results[$];
    int         err_count;
    int         items_sent;
    bit         no_gaps;

    task automatic report(string what, longint got, longint exp_v);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_v, $realtime);
        err_count++;
    endtask

    // greedy cover size for interval length d; also returns the smallest next gap
    function automatic int cover_count(longint d, output longint next_gap);
        int     k;
        int     i;
        longint lo;
        longint nx;
        k = 0;
        i = 0;
        next_gap = END_VAL;
        while (i < set_cnt) begin
            lo = set_vals[i];
            k++;
            while (i + 1 < set_cnt && set_vals[i + 1] <= lo + d)
                i++;
            i++;
            nx = (i < set_cnt) ? set_vals[i] : END_VAL;
            if (nx - lo < next_gap)
                next_gap = nx - lo;
        end
        return k;
    endfunction

    function automatic void quantize_set();
        longint lim;
        longint d;
        longint nd;
        longint hi;
        longint excess;
        longint lo;
        longint mid;
        int     k;
        int     i;
        int     first;
        int     grp;
        lim = (cfg_max_entries != 0) ? cfg_max_entries : 1;
        d = 0;
        excess = 0;
        grp = 0;
        if (set_cnt > lim) begin
            excess = set_cnt - lim;
            void'(cover_count(0, nd));
            d = nd;
            do begin
                d = (d * 2 > SAT32) ? SAT32 : d * 2;
                k = cover_count(d, nd);
            end while (k > lim);
            hi = d;
            d = d / 2;
            k = cover_count(d, nd);
            while (k > lim) begin
                if (nd <= d) begin
                    d = hi;
                    break;
                end
                d = nd;
                k = cover_count(d, nd);
            end
        end
        cur_interval = d;
        i = 0;
        while (i < set_cnt) begin
            first = i;
            lo = set_vals[i];
            grp++;
            while (i + 1 < set_cnt && set_vals[i + 1] <= lo + d) begin
                i++;
                excess--;
                if (excess == 0)
                    d = 0;
            end
            mid = lo + (set_vals[i] - lo) / 2;
            for (int j = first; j <= i; j++) begin
                set_rnd[j] = mid;
                set_grp[j] = grp;
            end
            i++;
        end
        grp_cnt = grp;
        is_reduced = 1'b1;
    endfunction

    function automatic quant_result_t predict_cmd(logic [1:0] fn, logic signed [31:0] val,
                                                  logic [7:0] pos);
        quant_result_t r;
        longint v;
        int     i;
        v = val;
        r.orig = '0;
        r.rnd = '0;
        r.tidx = '0;
        i = 0;
        case (fn)
            svq_pkg::FUNC_INSERT: begin
                if (v == 0 && cfg_skip_zero)
                    r.st = svq_pkg::ST_ZERO;
                else if (v == END_VAL || is_reduced)
                    r.st = svq_pkg::ST_REJECT;
                else begin
                    while (i < set_cnt && set_vals[i] < v)
                        i++;
                    if (i < set_cnt && set_vals[i] == v)
                        r.st = svq_pkg::ST_DUP;
                    else if (set_cnt >= svq_pkg::STORE_DEPTH)
                        r.st = svq_pkg::ST_REJECT;
                    else begin
                        for (int j = set_cnt; j > i; j--)
                            set_vals[j] = set_vals[j - 1];
                        set_vals[i] = v;
                        set_cnt++;
                        r.st = svq_pkg::ST_INSERTED;
                    end
                end
            end
            svq_pkg::FUNC_REDUCE: begin
                quantize_set();
                r.st = svq_pkg::ST_REDUCED;
            end
            svq_pkg::FUNC_READ: begin
                if (pos < set_cnt) begin
                    r.st = svq_pkg::ST_ENTRY;
                    r.orig = set_vals[pos];
                    r.rnd = is_reduced ? set_rnd[pos] : set_vals[pos];
                    r.tidx = is_reduced ? set_grp[pos] : 0;
                end else
                    r.st = svq_pkg::ST_BADPOS;
            end
            default: begin
                set_cnt = 0;
                grp_cnt = 0;
                cur_interval = 0;
                is_reduced = 1'b0;
                r.st = svq_pkg::ST_CLEARED;
            end
        endcase
        r.dcount = set_cnt;
        r.tcount = grp_cnt;
        r.ilen = cur_interval;
        return r;
    endfunction

    // one command transfer, then the sender's gap
    task automatic issue_cmd(logic [1:0] fn, logic signed [31:0] val, logic [7:0] pos,
                             bit typed = 0, logic [2:0] typed_st = svq_pkg::ST_INSERTED);
        quant_result_t r;
        int gap;
        start <= 1'b1;
        func <= fn;
        value <= val;
        position <= pos;
        do @(posedge clk); while (busy);
        r = predict_cmd(fn, val, pos);
        if (typed && r.st !== typed_st)
            report("directed status", r.st, typed_st);
        pending_results.push_back(r);
        items_sent++;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] reg_idx, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx[0], 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(int max_e, bit skip_z);
        drain();
        apb_write(svq_pkg::REG_MAX_ENTRIES, max_e);
        apb_write(svq_pkg::REG_SKIP_ZERO, {31'd0, skip_z});
        cfg_max_entries = max_e & 16'hFFFF;
        cfg_skip_zero = skip_z;
    endtask

    function automatic logic signed [31:0] pick_value(int spread);
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 2 * spread) - spread;
            2: begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh80000000;
                    1:       return 32'sh7FFFFFFE;
                    2:       return 32'sh7FFFFFFF;
                    3:       return 0;
                    default: return -1;
                endcase
            end
            default: return ($urandom_range(0, 7) << 20) + $urandom_range(0, spread);
        endcase
    endfunction

    // result checker: the receiver always takes the result
    always @(posedge clk) begin
        quant_result_t e;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $display("MISMATCH unexpected result at %0t", $realtime);
                err_count++;
            end else begin
                e = pending_results.pop_front();
                if (status !== e.st) report("status", status, e.st);
                if (distinct_count !== e.dcount)
                    report("distinct_count", distinct_count, e.dcount);
                if (table_count !== e.tcount) report("table_count", table_count, e.tcount);
                if (interval_length !== e.ilen)
                    report("interval_length", interval_length, e.ilen);
                if (original_value !== e.orig)
                    report("original_value", original_value, e.orig);
                if (rounded_value !== e.rnd) report("rounded_value", rounded_value, e.rnd);
                if (table_index !== e.tidx) report("table_index", table_index, e.tidx);
            end
        end
    end

    initial begin
        #50_000_000;
        $display("sorted_value_set_quantizer_unit test failed");
        $finish;
    end

    initial begin
        cmd_row_t rows[$];
        int n_ins;
        int spread;
        int phase;
        int max_e;
        set_cnt = 0;
        grp_cnt = 0;
        cur_interval = 0;
        is_reduced = 1'b0;
        cfg_max_entries = 255;
        cfg_skip_zero = 1'b0;
        err_count = 0;
        items_sent = 0;
        no_gaps = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // an empty reduce locks inserts, so a clear follows it
        rows = '{
            '{svq_pkg::FUNC_READ,   0,             0,   1, svq_pkg::ST_BADPOS},
            '{svq_pkg::FUNC_REDUCE, 0,             0,   1, svq_pkg::ST_REDUCED},
            '{svq_pkg::FUNC_CLEAR,  0,             0,   1, svq_pkg::ST_CLEARED},
            '{svq_pkg::FUNC_INSERT, 0,             0,   1, svq_pkg::ST_INSERTED},
            '{svq_pkg::FUNC_INSERT, 32'sh80000000, 0,   1, svq_pkg::ST_INSERTED},
            '{svq_pkg::FUNC_INSERT, 32'sh7FFFFFFF, 0,   1, svq_pkg::ST_REJECT},
            '{svq_pkg::FUNC_INSERT, 32'sh7FFFFFFE, 0,   1, svq_pkg::ST_INSERTED},
            '{svq_pkg::FUNC_INSERT, 0,             0,   1, svq_pkg::ST_DUP},
            '{svq_pkg::FUNC_INSERT, 5,             0,   1, svq_pkg::ST_INSERTED},
            '{svq_pkg::FUNC_INSERT, 7,             0,   1, svq_pkg::ST_INSERTED},
            '{svq_pkg::FUNC_READ,   0,             0,   1, svq_pkg::ST_ENTRY},
            '{svq_pkg::FUNC_READ,   0,             255, 1, svq_pkg::ST_BADPOS},
            '{svq_pkg::FUNC_REDUCE, 0,             0,   1, svq_pkg::ST_REDUCED},
            '{svq_pkg::FUNC_READ,   0,             1,   0, svq_pkg::ST_ENTRY},
            '{svq_pkg::FUNC_INSERT, 9,             0,   1, svq_pkg::ST_REJECT},
            '{svq_pkg::FUNC_CLEAR,  0,             0,   1, svq_pkg::ST_CLEARED}
        };
        foreach (rows[i])
            issue_cmd(rows[i].fn, rows[i].val, rows[i].pos, rows[i].typed, rows[i].st);

        // zero skipping, and the smallest entry limit (zero acts as one)
        set_config(0, 1'b1);
        issue_cmd(svq_pkg::FUNC_INSERT, 0, 0, 1, svq_pkg::ST_ZERO);
        issue_cmd(svq_pkg::FUNC_INSERT, 32'sh80000000, 0);
        issue_cmd(svq_pkg::FUNC_INSERT, -3, 0);
        issue_cmd(svq_pkg::FUNC_INSERT, 32'sh7FFFFFFE, 0);
        issue_cmd(svq_pkg::FUNC_REDUCE, 0, 0, 1, svq_pkg::ST_REDUCED);
        issue_cmd(svq_pkg::FUNC_READ, 0, 1);
        issue_cmd(svq_pkg::FUNC_REDUCE, 0, 0);
        issue_cmd(svq_pkg::FUNC_READ, 0, 2);
        issue_cmd(svq_pkg::FUNC_CLEAR, 0, 0);

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            case ($urandom_range(0, 5))
                0:       max_e = 1;
                1:       max_e = 65535;
                2:       max_e = 0;
                3:       max_e = 255;
                default: max_e = $urandom_range(2, 20);
            endcase
            set_config(max_e, $urandom_range(0, 1));
            no_gaps = ($urandom_range(0, 3) == 0);
            spread = $urandom_range(0, 1) ? 30 : 100000;
            n_ins = (phase == 2) ? 262 : $urandom_range(2, 40);
            issue_cmd(svq_pkg::FUNC_CLEAR, 0, 0);
            for (int i = 0; i < n_ins; i++) begin
                if ($urandom_range(0, 15) == 0)
                    issue_cmd(svq_pkg::FUNC_READ, 0, $urandom);
                else
                    issue_cmd(svq_pkg::FUNC_INSERT,
                              (phase == 2) ? $urandom : pick_value(spread), 0);
            end
            if ($urandom_range(0, 7) != 0) begin
                issue_cmd(svq_pkg::FUNC_REDUCE, 0, 0);
                repeat ($urandom_range(1, 6))
                    issue_cmd(svq_pkg::FUNC_READ, 0, $urandom_range(0, set_cnt));
                if ($urandom_range(0, 2) == 0)
                    issue_cmd(svq_pkg::FUNC_INSERT, pick_value(spread), 0);
                if ($urandom_range(0, 2) == 0) begin
                    issue_cmd(svq_pkg::FUNC_REDUCE, 0, 0);
                    issue_cmd(svq_pkg::FUNC_READ, 0, $urandom);
                end
            end
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("sorted_value_set_quantizer_unit test passed");
        else
            $display("sorted_value_set_quantizer_unit test failed");
        $finish;
    end
endmodule
